[src/ilce_pkg.sv]
// shared types, constants and functions for the l4 checksum engine
`timescale 1ns / 1ps

package ilce_pkg;

  localparam int POS_W       = 15;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [15:0] PROTO_UDP = 16'd17;
  localparam logic [15:0] PROTO_TCP = 16'd6;

  typedef enum logic [1:0] {
    MODE_IP   = 2'd0,
    MODE_UDP  = 2'd1,
    MODE_TCP  = 2'd2,
    MODE_ICMP = 2'd3
  } mode_t;

  typedef struct packed {
    logic        first;
    logic        keep;
    logic        add;
    logic        last;
    logic [15:0] word;
    logic [15:0] init_sum;
    logic [5:0]  header_bytes;
  } qentry_t;

  function automatic logic [3:0] check_pos(input mode_t mode);
    logic [3:0] pos;
    unique case (mode)
      MODE_IP:   pos = 4'd5;
      MODE_UDP:  pos = 4'd3;
      MODE_TCP:  pos = 4'd8;
      MODE_ICMP: pos = 4'd1;
      default:   pos = 4'd5;
    endcase
    return pos;
  endfunction

  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'b0, t[16]};
  endfunction

endpackage

[src/ip_l4_checksum_engine.sv]
// top level of the ip / udp / tcp / icmp checksum engine
//
// Takes one 16-bit word per cycle while the queue is not full, and returns one result
// per segment on the word marked last. A classifying front end feeds a queue of
// QUEUE_DEPTH entries; the accumulator behind it does one end-around-carry add per
// cycle, and that accumulator loop sets the rate of one word per cycle. A result
// appears on m_tvalid once its last word is popped from the queue into the output
// register; input is still accepted while a result waits, until the queue fills.
`timescale 1ns / 1ps

module ip_l4_checksum_engine
  import ilce_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // data_word, byte_count, address_pair
  input  logic [1:0]  s_tuser,   // req_type
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // checksum, carried_checksum, matches_res, header_bytes, pad
);

  qentry_t push_entry;
  qentry_t pop_entry;
  logic    full;
  logic    not_empty;
  logic    pop;
  logic    accept;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  ilce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .req_type     (s_tuser),
    .data_word    (s_tdata[15:0]),
    .byte_count   (s_tdata[31:16]),
    .address_pair (s_tdata[95:32]),
    .last_word    (s_tlast),
    .entry        (push_entry)
  );

  ilce_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .pop_entry  (pop_entry)
  );

  ilce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .valid    (not_empty),
    .entry    (pop_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[src/ilce_front.sv]
// front end: tracks word position and mode, classifies each word for the accumulator
`timescale 1ns / 1ps

module ilce_front
  import ilce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  req_type,
  input  logic [15:0] data_word,
  input  logic [15:0] byte_count,
  input  logic [63:0] address_pair,
  input  logic        last_word,
  output qentry_t     entry
);

  logic [POS_W-1:0] word_position;
  mode_t            held_mode;
  logic             odd_length;
  logic [5:0]       held_header_bytes;

  logic        first;
  mode_t       mode;
  logic [5:0]  hb;
  logic        odd;
  logic        keep;
  logic        below_hdr;
  logic [15:0] proto;
  logic [18:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;

  always_comb begin
    first = (word_position == '0);
    mode  = first ? mode_t'(req_type) : held_mode;
    if (first) begin
      hb  = (mode == MODE_IP) ? {data_word[11:8], 2'b00} : 6'd0;
      odd = (mode != MODE_IP) && byte_count[0];
    end else begin
      hb  = held_header_bytes;
      odd = odd_length;
    end
    keep      = (word_position == POS_W'(check_pos(mode)));
    below_hdr = (word_position < POS_W'(hb[5:1]));

    // pseudo-header: length, protocol and both addresses
    proto = (mode == MODE_UDP) ? PROTO_UDP : PROTO_TCP;
    total = {3'b0, byte_count} + {3'b0, proto}
          + {3'b0, address_pair[63:48]} + {3'b0, address_pair[47:32]}
          + {3'b0, address_pair[31:16]} + {3'b0, address_pair[15:0]};
    fold1 = {1'b0, total[15:0]} + {14'b0, total[18:16]};
    fold2 = fold1[15:0] + {15'b0, fold1[16]};

    entry.first        = first;
    entry.keep         = keep;
    entry.add          = !keep && ((mode != MODE_IP) || below_hdr);
    entry.last         = last_word;
    entry.word         = (last_word && odd && !keep) ? {data_word[15:8], 8'h00} : data_word;
    entry.init_sum     = (mode == MODE_UDP || mode == MODE_TCP) ? fold2 : 16'd0;
    entry.header_bytes = hb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position     <= '0;
      held_mode         <= MODE_IP;
      odd_length        <= 1'b0;
      held_header_bytes <= '0;
    end else if (accept) begin
      held_mode         <= mode;
      odd_length        <= odd;
      held_header_bytes <= hb;
      if (last_word) begin
        word_position <= '0;
      end else if (word_position != POS_MAX) begin
        word_position <= word_position + 1'b1;
      end
    end
  end

endmodule

[src/ilce_queue.sv]
// small fifo of classified words between front and back
`timescale 1ns / 1ps

module ilce_queue
  import ilce_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t push_entry,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output qentry_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qentry_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/ilce_back.sv]
// back end: ones' complement accumulator and result register
`timescale 1ns / 1ps

module ilce_back
  import ilce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  qentry_t     entry,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata
);

  logic [15:0] sum;
  logic [15:0] carried;
  logic [5:0]  held_hb;

  logic [15:0] out_checksum;
  logic [15:0] out_carried;
  logic        out_match;
  logic [5:0]  out_hb;

  logic [15:0] base_sum;
  logic [15:0] sum_next;
  logic [15:0] carried_next;
  logic [5:0]  hb_next;
  logic [15:0] cs;

  always_comb begin
    pop          = valid && (!entry.last || !m_tvalid || m_tready);
    base_sum     = entry.first ? entry.init_sum : sum;
    sum_next     = entry.add ? oc_add(base_sum, entry.word) : base_sum;
    carried_next = entry.keep ? entry.word : (entry.first ? 16'd0 : carried);
    hb_next      = entry.first ? entry.header_bytes : held_hb;
    cs           = ~sum_next;
  end

  assign m_tdata = {1'b0, out_hb, out_match, out_carried, out_checksum};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sum      <= '0;
      carried  <= '0;
      held_hb  <= '0;
    end else begin
      if (pop && entry.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        sum     <= entry.last ? 16'd0 : sum_next;
        carried <= carried_next;
        held_hb <= hb_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.last) begin
      out_checksum <= cs;
      out_carried  <= carried_next;
      out_match    <= (cs == carried_next);
      out_hb       <= hb_next;
    end
  end

endmodule

[src/ilce_checker.sv]
// port-level assertions for the checksum engine, bound to the top level
`timescale 1ns / 1ps

module ilce_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_match_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[32] == (m_tdata[15:0] == m_tdata[31:16])))
    else $error("match flag disagrees with checksums");

  a_header_align: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[34:33] == 2'b00) && !m_tdata[39])
    else $error("header length not a multiple of four or pad bit set");

endmodule

bind ip_l4_checksum_engine ilce_checker u_ilce_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/ip_l4_checksum_engine_tb.sv]
// testbench for the ip / udp / tcp / icmp checksum engine
`timescale 1ns / 1ps

module ip_l4_checksum_engine_tb;
  import ilce_pkg::*;

  typedef struct packed {
    logic [15:0] sum;
    logic [14:0] pos;
    mode_t       mode;
    logic        odd;
    logic [15:0] carried;
    logic [5:0]  hdr;
  } engine_state_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] carried;
    logic        match;
    logic [5:0]  hdr;
  } csum_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // data_word, byte_count, address_pair
  logic [1:0]  s_tuser = '0;   // req_type
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // checksum, carried_checksum, matches_res, header_bytes, pad

  engine_state_t engine;
  csum_result_t  expected_sums[$];
  logic [15:0]   seg_words[$];
  int            sent_words = 0;
  int            burst_left = 0;
  bit            gapless = 1'b0;
  int            mismatches = 0;
  logic [31:0]   cycle_count = '0;

  ip_l4_checksum_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic int carried_slot(input mode_t mode);
    case (mode)
      MODE_IP:  return 5;
      MODE_UDP: return 3;
      MODE_TCP: return 8;
      default:  return 1;
    endcase
  endfunction

  // one accepted word; returns 1 when the word closes a segment
  function automatic bit advance_checksum(inout engine_state_t st, input logic [1:0] kind,
                                          input logic [15:0] w, input logic [15:0] bytes,
                                          input logic [63:0] addr, input logic lst,
                                          output csum_result_t res);
    logic [15:0] s;
    logic [15:0] word;
    word = w;
    res = '0;
    if (st.pos == '0) begin
      st.mode    = mode_t'(kind);
      st.sum     = '0;
      st.carried = '0;
      st.hdr     = (st.mode == MODE_IP) ? {w[11:8], 2'b00} : 6'd0;
      st.odd     = (st.mode != MODE_IP) ? bytes[0] : 1'b0;
      if (st.mode == MODE_UDP || st.mode == MODE_TCP) begin
        s = fold_add(16'd0, bytes);
        s = fold_add(s, (st.mode == MODE_UDP) ? PROTO_UDP : PROTO_TCP);
        s = fold_add(s, addr[63:48]);
        s = fold_add(s, addr[47:32]);
        s = fold_add(s, addr[31:16]);
        s = fold_add(s, addr[15:0]);
        st.sum = s;
      end
    end
    if (int'(st.pos) == carried_slot(st.mode)) begin
      st.carried = w;
    end else if (st.mode != MODE_IP || st.pos < (st.hdr >> 1)) begin
      if (lst && st.odd) word[7:0] = 8'h00;
      st.sum = fold_add(st.sum, word);
    end
    if (st.pos != POS_MAX) st.pos = st.pos + 1'b1;
    if (!lst) return 1'b0;
    res.checksum = ~st.sum;
    res.carried  = st.carried;
    res.match    = (res.checksum == st.carried);
    res.hdr      = st.hdr;
    st.pos = '0;
    st.sum = '0;
    return 1'b1;
  endfunction

  function automatic csum_result_t preview_segment(input mode_t mode, input logic [15:0] bytes,
                                                   input logic [63:0] addr);
    engine_state_t st;
    csum_result_t  r;
    st = '0;
    r = '0;
    foreach (seg_words[i])
      void'(advance_checksum(st, mode, seg_words[i], bytes, addr,
                             i == seg_words.size() - 1, r));
    return r;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [15:0] w,
                           input logic [15:0] bytes, input logic [63:0] addr, input logic lst);
    csum_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!gapless && $urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {addr, bytes, w};
    s_tuser  <= kind;
    s_tlast  <= lst;
    do @(posedge clk); while (s_tready !== 1'b1);
    sent_words++;
    if (advance_checksum(engine, kind, w, bytes, addr, lst, r)) expected_sums.push_back(r);
  endtask

  // words after the first carry random side fields, which the engine must ignore
  task automatic send_segment(input mode_t mode, input logic [15:0] bytes,
                              input logic [63:0] addr, input bit fix_carried);
    csum_result_t r;
    int slot;
    slot = carried_slot(mode);
    if (fix_carried && seg_words.size() > slot) begin
      r = preview_segment(mode, bytes, addr);
      seg_words[slot] = r.checksum;
    end
    foreach (seg_words[i]) begin
      if (i == 0)
        send_word(mode, seg_words[i], bytes, addr, seg_words.size() == 1);
      else
        send_word(2'($urandom), seg_words[i], 16'($urandom), {$urandom, $urandom},
                  i == seg_words.size() - 1);
    end
    seg_words.delete();
  endtask

  task automatic test_ip_header();
    // header of 4 words: word 4 ignored, word 5 kept though outside the header
    seg_words = '{16'h4245, 16'hFFFF, 16'h8001, 16'h0000, 16'h1234, 16'h0000};
    send_segment(MODE_IP, 16'd13, 64'h0, 1'b1);
    // maximum ihl on a one-word segment, odd count without padding
    seg_words = '{16'hFFFF};
    send_segment(MODE_IP, 16'hFFFF, {64{1'b1}}, 1'b0);
  endtask

  task automatic test_l4_pseudo_header();
    // odd udp length, but the last word sits at the checksum position, kept unpadded
    seg_words = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    send_segment(MODE_UDP, 16'd7, {64{1'b1}}, 1'b0);
    // short tcp segment, checksum position never reached
    seg_words = '{16'h0000, 16'h0000, 16'h0000};
    send_segment(MODE_TCP, 16'd0, 64'h0, 1'b0);
    // icmp last word sits at the checksum position, kept unpadded
    seg_words = '{16'h0800, 16'h12FF};
    send_segment(MODE_ICMP, 16'd3, 64'h0, 1'b0);
    seg_words = '{16'h0000};
    send_segment(MODE_ICMP, 16'd1, 64'h0, 1'b0);
  endtask

  task automatic test_udp_zero_sum();
    csum_result_t r;
    seg_words = '{16'h1234, 16'hABCD, 16'h000A, 16'h0000, 16'h0000};
    r = preview_segment(MODE_UDP, 16'd10, 64'hC0A8_0001_0A00_0002);
    seg_words[4] = r.checksum;
    send_segment(MODE_UDP, 16'd10, 64'hC0A8_0001_0A00_0002, 1'b0);
  endtask

  task automatic test_back_to_back();
    gapless = 1'b1;
    repeat (64) seg_words.push_back(pick_word());
    send_segment(MODE_TCP, 16'($urandom), {$urandom, $urandom}, 1'b0);
    gapless = 1'b0;
  endtask

  task automatic test_random_segments();
    mode_t       mode;
    int          len;
    logic [3:0]  ihl;
    logic [15:0] bytes;
    while (sent_words < 650) begin
      mode = mode_t'($urandom_range(0, 3));
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 48) : $urandom_range(1, 20);
      ihl = 4'($urandom_range(5, 15));
      if (mode == MODE_IP && $urandom_range(0, 9) < 7) begin
        len = 2 * ihl + $urandom_range(0, 4);
        seg_words.push_back({4'h4, ihl, 8'($urandom)});
      end else begin
        seg_words.push_back(pick_word());
      end
      while (seg_words.size() < len) seg_words.push_back(pick_word());
      case ($urandom_range(0, 9))
        0, 1, 2, 3: bytes = 16'(2 * len);
        4, 5, 6:    bytes = 16'(2 * len - 1);
        default:    bytes = 16'($urandom);
      endcase
      send_segment(mode, bytes, {$urandom, $urandom}, $urandom_range(0, 1));
    end
  endtask

  always @(posedge clk) begin
    csum_result_t got;
    csum_result_t want;
    cycle_count <= cycle_count + 1'b1;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got.checksum = m_tdata[15:0];
      got.carried  = m_tdata[31:16];
      got.match    = m_tdata[32];
      got.hdr      = m_tdata[38:33];
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: checksum %h carried %h match %b hdr %0d",
                   got.checksum, got.carried, got.match, got.hdr);
      end else begin
        want = expected_sums.pop_front();
        if (got.checksum !== want.checksum || got.carried !== want.carried ||
            got.match !== want.match || got.hdr !== want.hdr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: checksum %h/%h carried %h/%h match %b/%b hdr %0d/%0d",
                     want.checksum, got.checksum, want.carried, got.carried,
                     want.match, got.match, want.hdr, got.hdr);
        end
      end
    end
    case (cycle_count[9:8])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_tready <= (cycle_count[3:0] < 4'd4);
      default: m_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  initial begin
    int drain_wait;
    engine = '0;
    drain_wait = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_ip_header();
    test_l4_pseudo_header();
    test_udp_zero_sum();
    test_back_to_back();
    test_random_segments();
    s_tvalid <= 1'b0;
    while (expected_sums.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (10) @(posedge clk);
    mismatches += expected_sums.size();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
